// ===== rtl/ptc_pkg.sv =====
// Shared types and constants for the pressure and temperature compensation pipeline
`default_nettype none

package ptc_pkg;

   localparam logic [2:0] REG_T1_T2 = 3'd0;
   localparam logic [2:0] REG_T3_P1 = 3'd1;
   localparam logic [2:0] REG_P2_P3 = 3'd2;
   localparam logic [2:0] REG_P4_P5 = 3'd3;
   localparam logic [2:0] REG_P6_P7 = 3'd4;
   localparam logic [2:0] REG_P8_P9 = 3'd5;
   localparam logic [2:0] REG_MODE  = 3'd6;

   localparam logic [1:0] MODE_TEMP  = 2'd0;
   localparam logic [1:0] MODE_PRESS = 2'd1;
   localparam logic [1:0] MODE_BOTH  = 2'd2;

   localparam logic [32:0] T_FINE_OFFSET = 33'd128000;
   localparam logic [20:0] ADC_FULL      = 21'd1048576;
   localparam logic [63:0] P1_BIAS       = 64'h0000_8000_0000_0000;
   localparam logic [63:0] P_DIV_SCALE   = 64'd3125;

   typedef struct packed {
      logic [15:0] t1;
      logic [15:0] t2;
      logic [15:0] t3;
      logic [15:0] p1;
      logic [15:0] p2;
      logic [15:0] p3;
      logic [15:0] p4;
      logic [15:0] p5;
      logic [15:0] p6;
      logic [15:0] p7;
      logic [15:0] p8;
      logic [15:0] p9;
   } cal_type;

   typedef struct packed {
      logic [19:0] adc_p;
      logic [31:0] temp;
      logic        want_t;
      logic        want_p;
   } side_type;

   typedef struct packed {
      side_type side;
      logic     neg;
      logic     zero;
   } div_side_type;

   typedef struct packed {
      logic signed [31:0] temperature_centi;
      logic [31:0]        pressure_q24_8;
      logic               temperature_valid;
      logic               pressure_valid;
   } rsp_word_type;

endpackage

`default_nettype wire

// ===== rtl/ptc_ifs.sv =====
// Request and response channel interfaces
`default_nettype none

interface ptc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] press_msb;
   logic [7:0] press_lsb;
   logic [7:0] press_xlsb;
   logic [7:0] temp_msb;
   logic [7:0] temp_lsb;
   logic [7:0] temp_xlsb;
   modport source (output valid, press_msb, press_lsb, press_xlsb, temp_msb, temp_lsb,
                   temp_xlsb, input ready);
   modport sink (input valid, press_msb, press_lsb, press_xlsb, temp_msb, temp_lsb,
                 temp_xlsb, output ready);
endinterface

interface ptc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] temperature_centi;
   logic [31:0]        pressure_q24_8;
   logic               temperature_valid;
   logic               pressure_valid;
   modport source (output valid, temperature_centi, pressure_q24_8, temperature_valid,
                   pressure_valid, input ready);
   modport sink (input valid, temperature_centi, pressure_q24_8, temperature_valid,
                 pressure_valid, output ready);
endinterface

`default_nettype wire

// ===== rtl/ptc_temp.sv =====
// Temperature compensation stages producing the fine term and centidegrees
`default_nettype none

module ptc_temp import ptc_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         en,
   input  wire logic         in_valid,
   input  wire logic [19:0]  adc_t,
   input  wire side_type     side_in,
   input  wire cal_type      cal,
   output logic              out_valid,
   output logic [32:0]       v1,
   output side_type          side_out
);

   logic [4:0]         vld_ff;
   side_type           side_ff [0:4];
   logic [18:0]        a0_ff, a0_in;
   logic [16:0]        d_ff, d_in;
   logic signed [31:0] pa_ff, pa_in;
   logic signed [31:0] dd_ff, dd_in;
   logic signed [31:0] a_ff, a_in;
   logic signed [31:0] pb_ff, pb_in;
   logic signed [31:0] fine_ff, fine_in;
   logic [32:0]        v1_ff, v1_in;
   logic signed [31:0] b0;
   logic [31:0]        t5;
   logic signed [31:0] temp;
   side_type           side_t5;

   always_comb begin
      a0_in   = {2'b00, adc_t[19:3]} - {2'b00, cal.t1, 1'b0};
      d_in    = {1'b0, adc_t[19:4]} - {1'b0, cal.t1};
      pa_in   = $signed(a0_ff) * $signed(cal.t2);
      dd_in   = $signed(d_ff) * $signed(d_ff);
      a_in    = pa_ff >>> 11;
      b0      = dd_ff >>> 12;
      pb_in   = $signed(b0[19:0]) * $signed(cal.t3);
      fine_in = a_ff + (pb_ff >>> 14);
      t5      = {fine_ff[29:0], 2'b00} + fine_ff + 32'd128;
      temp    = $signed(t5) >>> 8;
      v1_in   = {fine_ff[31], fine_ff} - T_FINE_OFFSET;
      side_t5 = side_ff[3];
      side_t5.temp = temp;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_in;
         side_ff[1] <= side_ff[0];
         side_ff[2] <= side_ff[1];
         side_ff[3] <= side_ff[2];
         side_ff[4] <= side_t5;
         a0_ff      <= a0_in;
         d_ff       <= d_in;
         pa_ff      <= pa_in;
         dd_ff      <= dd_in;
         a_ff       <= a_in;
         pb_ff      <= pb_in;
         fine_ff    <= fine_in;
         v1_ff      <= v1_in;
      end
   end

   assign out_valid = vld_ff[4];
   assign v1        = v1_ff;
   assign side_out  = side_ff[4];

endmodule

`default_nettype wire

// ===== rtl/ptc_var.sv =====
// Pressure coefficient stages forming the divider operands
`default_nettype none

module ptc_var import ptc_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         en,
   input  wire logic         in_valid,
   input  wire logic [32:0]  v1,
   input  wire side_type     side_in,
   input  wire cal_type      cal,
   output logic              out_valid,
   output logic [63:0]       mag_num,
   output logic [63:0]       mag_den,
   output div_side_type      dside_out
);

   logic [5:0]         vld_ff;
   side_type           side_ff [0:4];
   logic signed [63:0] sq_ff, sq_in;
   logic signed [63:0] m5_ff, m5_in;
   logic signed [63:0] m2_ff, m2_in;
   logic signed [63:0] x6_ff, x6_in;
   logic signed [63:0] x3_ff, x3_in;
   logic signed [63:0] m5b_ff, m2b_ff;
   logic signed [63:0] v2_ff, v2_in;
   logic signed [63:0] v1b_ff, v1b_in;
   logic [63:0]        y_ff, y_in;
   logic [63:0]        num0_ff, num0_in;
   logic signed [63:0] v1c_ff, v1c_in;
   logic [63:0]        num_ff, num_in;
   logic [63:0]        mn_ff, md_ff;
   div_side_type       dside_ff, dside_in;
   logic signed [63:0] p4_s;
   logic [20:0]        pr0;

   always_comb begin
      sq_in   = $signed(v1) * $signed(v1);
      m5_in   = $signed(v1) * $signed(cal.p5);
      m2_in   = $signed(v1) * $signed(cal.p2);
      x6_in   = sq_ff * $signed(cal.p6);
      x3_in   = sq_ff * $signed(cal.p3);
      p4_s    = $signed(cal.p4);
      v2_in   = x6_ff + (m5b_ff <<< 17) + (p4_s <<< 35);
      v1b_in  = (x3_ff >>> 8) + (m2b_ff <<< 12);
      y_in    = (P1_BIAS + v1b_ff) * {48'd0, cal.p1};
      pr0     = ADC_FULL - {1'b0, side_ff[2].adc_p};
      num0_in = {12'd0, pr0, 31'd0} - v2_ff;
      v1c_in  = $signed(y_ff) >>> 33;
      num_in  = num0_ff * P_DIV_SCALE;
      dside_in.side = side_ff[4];
      dside_in.neg  = num_ff[63] ^ v1c_ff[63];
      dside_in.zero = (v1c_ff == 64'sd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[4:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_in;
         side_ff[1] <= side_ff[0];
         side_ff[2] <= side_ff[1];
         side_ff[3] <= side_ff[2];
         side_ff[4] <= side_ff[3];
         sq_ff      <= sq_in;
         m5_ff      <= m5_in;
         m2_ff      <= m2_in;
         x6_ff      <= x6_in;
         x3_ff      <= x3_in;
         m5b_ff     <= m5_ff;
         m2b_ff     <= m2_ff;
         v2_ff      <= v2_in;
         v1b_ff     <= v1b_in;
         y_ff       <= y_in;
         num0_ff    <= num0_in;
         v1c_ff     <= v1c_in;
         num_ff     <= num_in;
         mn_ff      <= num_ff[63] ? (64'd0 - num_ff) : num_ff;
         md_ff      <= v1c_ff[63] ? (64'd0 - v1c_ff) : v1c_ff;
         dside_ff   <= dside_in;
      end
   end

   assign out_valid = vld_ff[5];
   assign mag_num   = mn_ff;
   assign mag_den   = md_ff;
   assign dside_out = dside_ff;

endmodule

`default_nettype wire

// ===== rtl/ptc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage
`default_nettype none

module ptc_div import ptc_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         en,
   input  wire logic         in_valid,
   input  wire logic [63:0]  mag_num,
   input  wire logic [63:0]  mag_den,
   input  wire div_side_type dside_in,
   output logic              out_valid,
   output logic [63:0]       quot,
   output div_side_type      dside_out
);

   logic         vld_ff [1:64];
   logic [63:0]  rem_ff [1:64];
   logic [63:0]  nq_ff  [1:64];
   logic [63:0]  den_ff [1:64];
   div_side_type ds_ff  [1:64];

   for (genvar k = 0; k < 64; k++) begin : g_step
      logic         vld_cur;
      logic [63:0]  rem_cur;
      logic [63:0]  nq_cur;
      logic [63:0]  den_cur;
      div_side_type ds_cur;
      logic [64:0]  trial;
      logic [64:0]  diff;
      logic         ge;

      if (k == 0) begin : g_head
         assign vld_cur = in_valid;
         assign rem_cur = '0;
         assign nq_cur  = mag_num;
         assign den_cur = mag_den;
         assign ds_cur  = dside_in;
      end else begin : g_body
         assign vld_cur = vld_ff[k];
         assign rem_cur = rem_ff[k];
         assign nq_cur  = nq_ff[k];
         assign den_cur = den_ff[k];
         assign ds_cur  = ds_ff[k];
      end

      assign trial = {rem_cur, nq_cur[63]};
      assign diff  = trial - {1'b0, den_cur};
      assign ge    = (trial >= {1'b0, den_cur});

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (en) begin
            vld_ff[k+1] <= vld_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1] <= ge ? diff[63:0] : trial[63:0];
            nq_ff[k+1]  <= {nq_cur[62:0], ge};
            den_ff[k+1] <= den_cur;
            ds_ff[k+1]  <= ds_cur;
         end
      end
   end

   assign out_valid = vld_ff[64];
   assign quot      = nq_ff[64];
   assign dside_out = ds_ff[64];

endmodule

`default_nettype wire

// ===== rtl/ptc_final.sv =====
// Final pressure correction stages and result word assembly
`default_nettype none

module ptc_final import ptc_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         en,
   input  wire logic         in_valid,
   input  wire logic [63:0]  quot,
   input  wire div_side_type dside_in,
   input  wire cal_type      cal,
   output logic              out_valid,
   output rsp_word_type      word
);

   logic [4:0]         vld_ff;
   div_side_type       ds_ff [0:3];
   logic signed [63:0] pr_ff [0:3];
   logic signed [63:0] pr_in;
   logic signed [63:0] s_ff, s_in;
   logic signed [63:0] s2_ff;
   logic signed [63:0] w9_ff, w9_in;
   logic signed [63:0] w8_ff, w8_in;
   logic signed [63:0] w8b_ff;
   logic [63:0]        pll_ff, pll_in;
   logic [31:0]        plh_ff, plh_in;
   logic [31:0]        phl_ff, phl_in;
   logic signed [63:0] v1p_ff, v1p_in;
   logic signed [63:0] v2p_ff, v2p_in;
   logic [63:0]        prod;
   logic signed [63:0] sum;
   logic signed [63:0] pr2;
   logic signed [63:0] p7_s;
   rsp_word_type       word_ff, word_in;

   always_comb begin
      pr_in  = dside_in.neg ? $signed(64'd0 - quot) : $signed(quot);
      s_in   = pr_in >>> 13;
      w9_in  = s_ff * $signed(cal.p9);
      w8_in  = pr_ff[0] * $signed(cal.p8);
      pll_in = {32'd0, w9_ff[31:0]} * {32'd0, s2_ff[31:0]};
      plh_in = w9_ff[31:0] * s2_ff[63:32];
      phl_in = w9_ff[63:32] * s2_ff[31:0];
      prod   = pll_ff + {plh_ff + phl_ff, 32'd0};
      v1p_in = $signed(prod) >>> 25;
      v2p_in = w8b_ff >>> 19;
      p7_s   = $signed(cal.p7);
      sum    = pr_ff[3] + v1p_ff + v2p_ff;
      pr2    = (sum >>> 8) + (p7_s <<< 4);
      word_in.temperature_valid = ds_ff[3].side.want_t;
      word_in.pressure_valid    = ds_ff[3].side.want_p;
      word_in.temperature_centi = ds_ff[3].side.want_t ? $signed(ds_ff[3].side.temp) : 32'sd0;
      word_in.pressure_q24_8    = (ds_ff[3].side.want_p && !ds_ff[3].zero) ?
                                  pr2[31:0] : 32'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ds_ff[0] <= dside_in;
         ds_ff[1] <= ds_ff[0];
         ds_ff[2] <= ds_ff[1];
         ds_ff[3] <= ds_ff[2];
         pr_ff[0] <= pr_in;
         pr_ff[1] <= pr_ff[0];
         pr_ff[2] <= pr_ff[1];
         pr_ff[3] <= pr_ff[2];
         s_ff     <= s_in;
         s2_ff    <= s_ff;
         w9_ff    <= w9_in;
         w8_ff    <= w8_in;
         w8b_ff   <= w8_ff;
         pll_ff   <= pll_in;
         plh_ff   <= plh_in;
         phl_ff   <= phl_in;
         v1p_ff   <= v1p_in;
         v2p_ff   <= v2p_in;
         word_ff  <= word_in;
      end
   end

   assign out_valid = vld_ff[4];
   assign word      = word_ff;

endmodule

`default_nettype wire

// ===== rtl/pressure_temperature_compensation_top.sv =====
// Top level: register port, compensation pipeline and output skid buffer
// Throughput: one word per cycle while the output buffer has room; the 64-stage
// divider pipeline sets the depth.
// The pipeline halts as a whole only when the two-entry output buffer is full.
// Reset (synchronous, active high) empties the pipeline and buffer, clears the
// calibration registers and sets the measure mode to both results.
`default_nettype none

module pressure_temperature_compensation_top import ptc_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   ptc_req_if.sink    req,
   ptc_rsp_if.source  rsp,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   logic [31:0]  t1_t2_ff, t3_p1_ff, p2_p3_ff, p4_p5_ff, p6_p7_ff, p8_p9_ff;
   logic [1:0]   mode_ff;
   logic         wr;
   logic [2:0]   idx;
   cal_type      cal;
   logic         en;
   logic [19:0]  adc_t;
   side_type     side_in;

   logic         t_valid, v_valid, d_valid, f_valid;
   logic [32:0]  v1;
   side_type     t_side;
   logic [63:0]  mag_num, mag_den, quot;
   div_side_type v_dside, d_dside;
   rsp_word_type f_word;

   rsp_word_type entry_ff [0:1];
   logic         wr_ptr_ff, rd_ptr_ff;
   logic [1:0]   count_ff, count_in;
   logic         push, pop;

   assign wr     = psel & penable & pwrite;
   assign idx    = paddr[4:2];
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_t2_ff <= '0;
         t3_p1_ff <= '0;
         p2_p3_ff <= '0;
         p4_p5_ff <= '0;
         p6_p7_ff <= '0;
         p8_p9_ff <= '0;
         mode_ff  <= MODE_BOTH;
      end else if (wr) begin
         unique case (idx)
            REG_T1_T2: t1_t2_ff <= pwdata;
            REG_T3_P1: t3_p1_ff <= pwdata;
            REG_P2_P3: p2_p3_ff <= pwdata;
            REG_P4_P5: p4_p5_ff <= pwdata;
            REG_P6_P7: p6_p7_ff <= pwdata;
            REG_P8_P9: p8_p9_ff <= pwdata;
            REG_MODE:  mode_ff  <= pwdata[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_T1_T2: prdata = t1_t2_ff;
         REG_T3_P1: prdata = t3_p1_ff;
         REG_P2_P3: prdata = p2_p3_ff;
         REG_P4_P5: prdata = p4_p5_ff;
         REG_P6_P7: prdata = p6_p7_ff;
         REG_P8_P9: prdata = p8_p9_ff;
         REG_MODE:  prdata = {30'd0, mode_ff};
         default:   prdata = '0;
      endcase
   end

   always_comb begin
      cal.t1 = t1_t2_ff[15:0];
      cal.t2 = t1_t2_ff[31:16];
      cal.t3 = t3_p1_ff[15:0];
      cal.p1 = t3_p1_ff[31:16];
      cal.p2 = p2_p3_ff[15:0];
      cal.p3 = p2_p3_ff[31:16];
      cal.p4 = p4_p5_ff[15:0];
      cal.p5 = p4_p5_ff[31:16];
      cal.p6 = p6_p7_ff[15:0];
      cal.p7 = p6_p7_ff[31:16];
      cal.p8 = p8_p9_ff[15:0];
      cal.p9 = p8_p9_ff[31:16];
      adc_t  = {req.temp_msb, req.temp_lsb, req.temp_xlsb[7:4]};
      side_in.adc_p  = {req.press_msb, req.press_lsb, req.press_xlsb[7:4]};
      side_in.temp   = '0;
      side_in.want_t = (mode_ff == MODE_TEMP) || (mode_ff == MODE_BOTH);
      side_in.want_p = (mode_ff == MODE_PRESS) || (mode_ff == MODE_BOTH);
   end

   assign en        = (count_ff != 2'd2);
   assign req.ready = en;

   ptc_temp u_temp (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req.valid),
      .adc_t    (adc_t),
      .side_in  (side_in),
      .cal      (cal),
      .out_valid(t_valid),
      .v1       (v1),
      .side_out (t_side)
   );

   ptc_var u_var (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (t_valid),
      .v1       (v1),
      .side_in  (t_side),
      .cal      (cal),
      .out_valid(v_valid),
      .mag_num  (mag_num),
      .mag_den  (mag_den),
      .dside_out(v_dside)
   );

   ptc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (v_valid),
      .mag_num  (mag_num),
      .mag_den  (mag_den),
      .dside_in (v_dside),
      .out_valid(d_valid),
      .quot     (quot),
      .dside_out(d_dside)
   );

   ptc_final u_final (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (d_valid),
      .quot     (quot),
      .dside_in (d_dside),
      .cal      (cal),
      .out_valid(f_valid),
      .word     (f_word)
   );

   assign push     = en & f_valid;
   assign pop      = rsp.valid & rsp.ready;
   assign count_in = count_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= f_word;
      end
   end

   assign rsp.valid             = (count_ff != 2'd0);
   assign rsp.temperature_centi = entry_ff[rd_ptr_ff].temperature_centi;
   assign rsp.pressure_q24_8    = entry_ff[rd_ptr_ff].pressure_q24_8;
   assign rsp.temperature_valid = entry_ff[rd_ptr_ff].temperature_valid;
   assign rsp.pressure_valid    = entry_ff[rd_ptr_ff].pressure_valid;

endmodule

`default_nettype wire
